// ===== src/psu_pkg.sv =====
// Shared types and constants for the particle state update pipeline.
// No dependencies; imported by psu_color_blend and particle_state_update.
package psu_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam longint unsigned TWO_PI_Q24 = 64'd105414357;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TIME_STEP      = 3'd0,
        REG_GRAVITY_ENABLE = 3'd1,
        REG_GRAVITY        = 3'd2,
        REG_SIZE_STEP      = 3'd3,
        REG_START_COLOR    = 3'd4,
        REG_END_COLOR      = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic en_s3;
        logic en_s4;
    } stage_ctl_t;

endpackage

// ===== src/psu_color_blend.sv =====
// One RGBA8 channel of the colour blend: multiply stage and saturate stage.
// Depends on psu_pkg (stage_ctl_t); instantiated four times by particle_state_update.
module psu_color_blend #(
    parameter int FRAC_BITS = psu_pkg::FRAC_BITS_DEF
) (
    input  logic                aclk,
    input  psu_pkg::stage_ctl_t ctl,
    input  logic [7:0]          start_ch,
    input  logic [7:0]          end_ch,
    input  logic [31:0]         phase,
    output logic [7:0]          ch_out
);
    import psu_pkg::*;

    logic signed [8:0]  diff;
    logic signed [32:0] phase_s;
    logic signed [41:0] prod_reg;
    logic signed [41:0] prod_next;
    logic signed [41:0] shifted;
    logic signed [41:0] blend;
    logic [7:0]         ch_reg;
    logic [7:0]         ch_next;

    assign diff      = $signed({1'b0, end_ch}) - $signed({1'b0, start_ch});
    assign phase_s   = $signed({1'b0, phase});
    assign prod_next = 42'(diff) * 42'(phase_s);

    assign shifted = prod_reg >>> FRAC_BITS;
    assign blend   = shifted + $signed({34'd0, start_ch});

    always_comb begin
        if (blend[41]) begin
            ch_next = 8'd0;
        end else if (|blend[40:8]) begin
            ch_next = 8'hFF;
        end else begin
            ch_next = blend[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en_s3) begin
            prod_reg <= prod_next;
        end
        if (ctl.en_s4) begin
            ch_reg <= ch_next;
        end
    end

    assign ch_out = ch_reg;

endmodule

// ===== src/particle_state_update.sv =====
// Top level of the particle state update: config registers and a four-stage pipeline.
// Depends on psu_pkg and psu_color_blend.
//
// Usage:
//   Input requests arrive on s_valid/s_ready with one particle per request;
//   each produces exactly one result request on m_valid/m_ready.
//   Configuration is written through cfg_wr_en/cfg_index/cfg_wdata, one register
//   per cycle; the user must write only while the pipeline holds no particle; the
//   block does not enforce this. A request runs through the stage 1 to 4 registers;
//   m_valid is the stage 4 valid bit. Throughput is one particle per cycle while
//   m_ready is high. Stage 1 forms the velocity, gravity and phase products and
//   updates size, angle and life, stage 2 adds and saturates, stage 3 forms the
//   colour products, stage 4 saturates the colour channels into the output register.
//   When m_ready is low the pipeline fills up behind the output register and
//   s_ready drops once every stage is occupied; nothing is dropped or repeated.
//   Reset clears all stage valid bits and loads the register defaults
//   (time_step 1092, gravity off, white to transparent black).
module particle_state_update #(
    parameter int FRAC_BITS = psu_pkg::FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [psu_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [psu_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [31:0]               s_pos_x,
    input  logic signed [31:0]               s_pos_y,
    input  logic signed [31:0]               s_pos_z,
    input  logic signed [31:0]               s_vel_x,
    input  logic signed [31:0]               s_vel_y,
    input  logic signed [31:0]               s_vel_z,
    input  logic signed [31:0]               s_size_in,
    input  logic [18:0]                      s_angle_in,
    input  logic signed [19:0]               s_angle_rate,
    input  logic [17:0]                      s_phase_in,
    input  logic [24:0]                      s_phase_rate,
    input  logic [30:0]                      s_life_in,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [31:0]               m_new_pos_x,
    output logic signed [31:0]               m_new_pos_y,
    output logic signed [31:0]               m_new_pos_z,
    output logic signed [31:0]               m_new_vel_z,
    output logic signed [31:0]               m_new_size,
    output logic [18:0]                      m_new_angle,
    output logic [31:0]                      m_new_phase,
    output logic [30:0]                      m_new_life,
    output logic                             m_alive,
    output logic [31:0]                      m_color_rgba
);
    import psu_pkg::*;

    localparam int TwoPiSh = 24 - FRAC_BITS;
    localparam longint unsigned TwoPiFull =
        (TWO_PI_Q24 + ((64'd1 << TwoPiSh) >> 1)) >> TwoPiSh;
    localparam logic signed [27:0] TwoPi = $signed({1'b0, TwoPiFull[26:0]});

    // configuration registers
    logic [15:0]        time_step_reg;
    logic               gravity_enable_reg;
    logic signed [31:0] gravity_reg;
    logic signed [31:0] size_step_reg;
    logic [31:0]        start_color_reg;
    logic [31:0]        end_color_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_step_reg      <= 16'd1092;
            gravity_enable_reg <= 1'b0;
            gravity_reg        <= 32'sd0;
            size_step_reg      <= 32'sd0;
            start_color_reg    <= 32'hFFFF_FFFF;
            end_color_reg      <= 32'd0;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_TIME_STEP:      time_step_reg      <= cfg_wdata[15:0];
                REG_GRAVITY_ENABLE: gravity_enable_reg <= cfg_wdata[0];
                REG_GRAVITY:        gravity_reg        <= $signed(cfg_wdata);
                REG_SIZE_STEP:      size_step_reg      <= $signed(cfg_wdata);
                REG_START_COLOR:    start_color_reg    <= cfg_wdata;
                REG_END_COLOR:      end_color_reg      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipeline control
    logic       v1_reg, v2_reg, v3_reg, v4_reg;
    logic       en1, en2, en3, en4;
    stage_ctl_t ctl;

    assign en4 = !v4_reg || m_ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign ctl = '{en_s3: en3, en_s4: en4};
    assign s_ready = en1;
    assign m_valid = v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // stage 1: products, size, angle, life
    logic signed [16:0] dt_s;
    logic signed [47:0] prod_x_next, prod_y_next, prod_z_next, prod_g_next;
    logic [40:0]        prod_p_next;
    logic signed [32:0] size_sum;
    logic signed [31:0] size_next;
    logic signed [27:0] ang_sum;
    logic signed [27:0] ang_fix;
    logic signed [31:0] life_sum;
    logic [30:0]        life_next;
    logic               alive_next;

    assign dt_s        = $signed({1'b0, time_step_reg});
    assign prod_x_next = 48'(s_vel_x) * 48'(dt_s);
    assign prod_y_next = 48'(s_vel_y) * 48'(dt_s);
    assign prod_z_next = 48'(s_vel_z) * 48'(dt_s);
    assign prod_g_next = 48'(gravity_reg) * 48'(dt_s);
    assign prod_p_next = 41'(s_phase_rate) * 41'(time_step_reg);

    assign size_sum = 33'(s_size_in) + 33'(size_step_reg);
    always_comb begin
        if (size_sum[32] != size_sum[31]) begin
            size_next = size_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            size_next = size_sum[31:0];
        end
    end

    assign ang_sum = $signed({9'd0, s_angle_in}) + 28'(s_angle_rate);
    always_comb begin
        if (ang_sum > TwoPi) begin
            ang_fix = ang_sum - TwoPi;
        end else if (ang_sum < 28'sd0) begin
            ang_fix = ang_sum + TwoPi;
        end else begin
            ang_fix = ang_sum;
        end
    end

    assign life_sum = $signed({1'b0, s_life_in}) - $signed({16'd0, time_step_reg});
    always_comb begin
        if (life_sum <= 32'sd0) begin
            life_next  = 31'd0;
            alive_next = 1'b0;
        end else begin
            life_next  = life_sum[30:0];
            alive_next = 1'b1;
        end
    end

    logic signed [47:0] s1_prod_x_reg, s1_prod_y_reg, s1_prod_z_reg, s1_prod_g_reg;
    logic [40:0]        s1_prod_p_reg;
    logic signed [31:0] s1_pos_x_reg, s1_pos_y_reg, s1_pos_z_reg, s1_vel_z_reg;
    logic signed [31:0] s1_size_reg;
    logic [18:0]        s1_angle_reg;
    logic [17:0]        s1_phase_in_reg;
    logic [30:0]        s1_life_reg;
    logic               s1_alive_reg;

    always_ff @(posedge aclk) begin
        if (en1) begin
            s1_prod_x_reg   <= prod_x_next;
            s1_prod_y_reg   <= prod_y_next;
            s1_prod_z_reg   <= prod_z_next;
            s1_prod_g_reg   <= prod_g_next;
            s1_prod_p_reg   <= prod_p_next;
            s1_pos_x_reg    <= s_pos_x;
            s1_pos_y_reg    <= s_pos_y;
            s1_pos_z_reg    <= s_pos_z;
            s1_vel_z_reg    <= s_vel_z;
            s1_size_reg     <= size_next;
            s1_angle_reg    <= ang_fix[18:0];
            s1_phase_in_reg <= s_phase_in;
            s1_life_reg     <= life_next;
            s1_alive_reg    <= alive_next;
        end
    end

    // stage 2: position, gravity, phase
    logic signed [47:0] sh_x, sh_y, sh_z, sh_g;
    logic [40:0]        sh_p;
    logic signed [48:0] vz_sum;
    logic signed [31:0] vz_next;
    logic [41:0]        ph_sum;
    logic [31:0]        ph_next;

    assign sh_x = s1_prod_x_reg >>> FRAC_BITS;
    assign sh_y = s1_prod_y_reg >>> FRAC_BITS;
    assign sh_z = s1_prod_z_reg >>> FRAC_BITS;
    assign sh_g = s1_prod_g_reg >>> FRAC_BITS;
    assign sh_p = s1_prod_p_reg >> FRAC_BITS;

    assign vz_sum = 49'(s1_vel_z_reg) + 49'(sh_g);
    always_comb begin
        if (!gravity_enable_reg) begin
            vz_next = s1_vel_z_reg;
        end else if ((vz_sum[48:31] != '0) && (vz_sum[48:31] != '1)) begin
            vz_next = vz_sum[48] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            vz_next = vz_sum[31:0];
        end
    end

    assign ph_sum  = {1'b0, sh_p} + {24'd0, s1_phase_in_reg};
    assign ph_next = (|ph_sum[41:32]) ? 32'hFFFF_FFFF : ph_sum[31:0];

    logic signed [31:0] s2_pos_x_reg, s2_pos_y_reg, s2_pos_z_reg, s2_vel_z_reg;
    logic signed [31:0] s2_size_reg;
    logic [18:0]        s2_angle_reg;
    logic [31:0]        s2_phase_reg;
    logic [30:0]        s2_life_reg;
    logic               s2_alive_reg;

    always_ff @(posedge aclk) begin
        if (en2) begin
            s2_pos_x_reg <= s1_pos_x_reg + sh_x[31:0];
            s2_pos_y_reg <= s1_pos_y_reg + sh_y[31:0];
            s2_pos_z_reg <= s1_pos_z_reg + sh_z[31:0];
            s2_vel_z_reg <= vz_next;
            s2_size_reg  <= s1_size_reg;
            s2_angle_reg <= s1_angle_reg;
            s2_phase_reg <= ph_next;
            s2_life_reg  <= s1_life_reg;
            s2_alive_reg <= s1_alive_reg;
        end
    end

    // stages 3 and 4: colour channels, hold the rest alongside
    logic [31:0] color_out;

    for (genvar ch = 0; ch < 4; ch++) begin : g_blend
        psu_color_blend #(
            .FRAC_BITS (FRAC_BITS)
        ) u_blend (
            .aclk     (aclk),
            .ctl      (ctl),
            .start_ch (start_color_reg[8*ch +: 8]),
            .end_ch   (end_color_reg[8*ch +: 8]),
            .phase    (s2_phase_reg),
            .ch_out   (color_out[8*ch +: 8])
        );
    end

    logic signed [31:0] s3_pos_x_reg, s3_pos_y_reg, s3_pos_z_reg, s3_vel_z_reg;
    logic signed [31:0] s3_size_reg;
    logic [18:0]        s3_angle_reg;
    logic [31:0]        s3_phase_reg;
    logic [30:0]        s3_life_reg;
    logic               s3_alive_reg;

    logic signed [31:0] s4_pos_x_reg, s4_pos_y_reg, s4_pos_z_reg, s4_vel_z_reg;
    logic signed [31:0] s4_size_reg;
    logic [18:0]        s4_angle_reg;
    logic [31:0]        s4_phase_reg;
    logic [30:0]        s4_life_reg;
    logic               s4_alive_reg;

    always_ff @(posedge aclk) begin
        if (en3) begin
            s3_pos_x_reg <= s2_pos_x_reg;
            s3_pos_y_reg <= s2_pos_y_reg;
            s3_pos_z_reg <= s2_pos_z_reg;
            s3_vel_z_reg <= s2_vel_z_reg;
            s3_size_reg  <= s2_size_reg;
            s3_angle_reg <= s2_angle_reg;
            s3_phase_reg <= s2_phase_reg;
            s3_life_reg  <= s2_life_reg;
            s3_alive_reg <= s2_alive_reg;
        end
        if (en4) begin
            s4_pos_x_reg <= s3_pos_x_reg;
            s4_pos_y_reg <= s3_pos_y_reg;
            s4_pos_z_reg <= s3_pos_z_reg;
            s4_vel_z_reg <= s3_vel_z_reg;
            s4_size_reg  <= s3_size_reg;
            s4_angle_reg <= s3_angle_reg;
            s4_phase_reg <= s3_phase_reg;
            s4_life_reg  <= s3_life_reg;
            s4_alive_reg <= s3_alive_reg;
        end
    end

    assign m_new_pos_x  = s4_pos_x_reg;
    assign m_new_pos_y  = s4_pos_y_reg;
    assign m_new_pos_z  = s4_pos_z_reg;
    assign m_new_vel_z  = s4_vel_z_reg;
    assign m_new_size   = s4_size_reg;
    assign m_new_angle  = s4_angle_reg;
    assign m_new_phase  = s4_phase_reg;
    assign m_new_life   = s4_life_reg;
    assign m_alive      = s4_alive_reg;
    assign m_color_rgba = color_out;

endmodule
